[design/dirc_pkg.sv]
`default_nettype none
package dirc_pkg;
    typedef enum logic [1:0] {
        SIDE_ERROR    = 2'd0,
        SIDE_FRONT    = 2'd1,
        SIDE_PARALLEL = 2'd2,
        SIDE_BACK     = 2'd3
    } side_t;

    localparam logic [2:0] CFG_RATE   = 3'd0;
    localparam logic [2:0] CFG_COUNT  = 3'd1;
    localparam logic [2:0] CFG_UPPER  = 3'd2;
    localparam logic [2:0] CFG_LOWER  = 3'd3;
    localparam logic [2:0] CFG_MARGIN = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic accum;     // add samples into sums
        logic clear;     // clear count and sums
        logic div_start; // load averaging divider
        logic div_step;  // one restoring step
        logic conv_load; // range check, load conversion divider
        logic conv_step; // one conversion step
        logic finish;    // update held values, build result
    } dirc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic sample_hit;  // this tick takes a sample
        logic spa_zero;
        logic reading_due; // count after accumulate reaches samples per average
    } dirc_status_t;
endpackage
`default_nettype wire

[design/dirc_ctrl.sv]
`default_nettype none
module dirc_ctrl (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_fire,
    input  wire                   out_busy,
    input  wire dirc_pkg::dirc_status_t status,
    output dirc_pkg::dirc_cmd_t   cmd,
    output logic                  idle
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_ACC, ST_DIV, ST_CONV_LD, ST_CONV, ST_FIN
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (!status.sample_hit)
                    state_next = ST_IDLE;
                else if (status.spa_zero)
                begin
                    cmd.clear  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.accum = 1'b1;
                    if (status.reading_due)
                    begin
                        cmd.div_start = 1'b1;
                        cnt_next      = 6'd0;
                        state_next    = ST_DIV;
                    end
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg == 6'd11)
                    state_next = ST_CONV_LD;
            end
            ST_CONV_LD:
            begin
                cmd.conv_load = 1'b1;
                cnt_next      = 6'd0;
                state_next    = ST_CONV;
            end
            ST_CONV:
            begin
                cmd.conv_step = 1'b1;
                cnt_next      = cnt_reg + 6'd1;
                if (cnt_reg == 6'd23)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_busy)
                begin
                    cmd.finish = 1'b1;
                    cmd.clear  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign idle = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end
endmodule
`default_nettype wire

[design/dirc_datapath.sv]
`default_nettype none
module dirc_datapath #(
    parameter int STORE_DEPTH = 10
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_fire,
    input  wire  [7:0]            front_sample,
    input  wire  [7:0]            back_sample,
    input  wire                   cfg_we,
    input  wire  [2:0]            cfg_idx,
    input  wire  [14:0]           cfg_data,
    input  wire dirc_pkg::dirc_cmd_t cmd,
    output dirc_pkg::dirc_status_t status,
    output logic [1:0]            side_state,
    output logic signed [15:0]    front_cm,
    output logic signed [15:0]    back_cm,
    output logic signed [15:0]    mean_cm,
    output logic                  front_ok,
    output logic                  back_ok
);
    // tick counter holds up to STORE_DEPTH and is compared with a target up to 11
    localparam int TW = ($clog2(STORE_DEPTH + 1) > 4) ? $clog2(STORE_DEPTH + 1) : 4;

    logic [6:0]  rate_reg;
    logic [3:0]  spa_reg;
    logic [7:0]  upper_reg, lower_reg;
    logic [14:0] margin_reg;
    logic [TW-1:0] tick_reg;
    logic [3:0]  taken_reg;
    logic [11:0] fsum_reg, bsum_reg;
    logic [7:0]  fs_reg, bs_reg;
    logic        hit_reg;
    logic signed [15:0] fheld_reg, bheld_reg;

    // averaging divider: two restoring dividers, 12 steps
    logic [11:0] fq_reg, bq_reg;
    logic [3:0]  fr_reg, br_reg;
    logic [3:0]  dv_reg;
    // conversion divider: |2N+D| / |2D| with 24 quotient bits
    logic [23:0] fnum_reg, bnum_reg;
    logic [26:0] fden_reg, bden_reg;
    logic [27:0] frem_reg, brem_reg;
    logic [23:0] fcq_reg, bcq_reg;
    logic        fneg_reg, bneg_reg, fok_reg, bok_reg;

    logic [6:0]  rate_c;
    logic [3:0]  tdiv;
    logic [3:0]  target;
    logic [TW-1:0] tick_inc;

    // target = 1 + (100 - rate) / 10, the quotient counted by threshold compares
    always_comb
    begin
        rate_c = (rate_reg > 7'd100) ? 7'd100 : rate_reg;
        tdiv   = 4'd0;
        for (int k = 1; k <= 10; k++)
        begin
            if (rate_c <= 7'(100 - 10 * k))
                tdiv = tdiv + 4'd1;
        end
        target   = 4'd1 + tdiv;
        tick_inc = tick_reg + 1'b1;
    end

    assign status.sample_hit  = hit_reg;
    assign status.spa_zero    = (spa_reg == 4'd0);
    assign status.reading_due = ((taken_reg + 4'd1) >= spa_reg);

    // one restoring step on a 4-bit divisor
    function automatic logic [16:0] dstep(input logic [11:0] q, input logic [3:0] r,
                                          input logic [3:0] d);
        logic [4:0] t;
        t = {r, q[11]};
        if (t >= {1'b0, d})
            return {4'(t - {1'b0, d}), q[10:0], 1'b1, 1'b0};
        else
            return {t[3:0], q[10:0], 1'b0, 1'b0};
    endfunction

    // r = floor((2N+D)/(2D)), N = 1305600000 - 10752 d, D = 100 d, d = 95x - 1071
    // 2N+D = 2611200000 - 21404 d stays positive; sign of the result is sign of d.
    // Returns {d negative, |2N+D| (32 bits), |2D| (27 bits)}.
    function automatic logic [59:0] cset(input logic [7:0] x);
        logic signed [15:0] d;
        logic signed [33:0] n2;
        logic [15:0]        ad;
        logic [31:0]        dd;
        d  = 16'sd95 * $signed({8'd0, x}) - 16'sd1071;
        n2 = 34'sd2611200000 - 34'sd21404 * 34'(d);
        ad = d[15] ? 16'(-d) : 16'(d);
        dd = 32'd200 * 32'(ad);
        return {d[15], n2[31:0], dd[26:0]};
    endfunction

    function automatic logic signed [15:0] sat(input logic [23:0] q, input logic neg,
                                               input logic rem_nz);
        logic signed [25:0] v;
        v = neg ? -$signed({2'b0, q}) - 26'(rem_nz) : $signed({2'b0, q});
        if (v > 26'sd32767) return 16'sh7fff;
        if (v < -26'sd32768) return 16'sh8000;
        return v[15:0];
    endfunction

    logic [59:0] fset, bset;
    logic [28:0] ftr, btr;
    logic signed [15:0] fnew, bnew, fcm, bcm;
    logic signed [16:0] diff, sum;
    logic [1:0] st;

    always_comb
    begin
        fset = cset(fq_reg[7:0]);
        bset = cset(bq_reg[7:0]);
        ftr  = {frem_reg, fnum_reg[23]} - {2'b0, fden_reg};
        btr  = {brem_reg, bnum_reg[23]} - {2'b0, bden_reg};
        fnew = sat(fcq_reg, fneg_reg, frem_reg != 0);
        bnew = sat(bcq_reg, bneg_reg, brem_reg != 0);
        fcm  = fok_reg ? fnew : fheld_reg;
        bcm  = bok_reg ? bnew : bheld_reg;
        diff = 17'(fcm) - 17'(bcm);
        sum  = 17'(fcm) + 17'(bcm);
        if (fok_reg && (!bok_reg || diff > $signed({2'b0, margin_reg})))
            st = dirc_pkg::SIDE_FRONT;
        else if (bok_reg && (!fok_reg || -diff > $signed({2'b0, margin_reg})))
            st = dirc_pkg::SIDE_BACK;
        else if (!fok_reg && !bok_reg)
            st = dirc_pkg::SIDE_ERROR;
        else
            st = dirc_pkg::SIDE_PARALLEL;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg   <= 7'd100;
            spa_reg    <= 4'd10;
            upper_reg  <= 8'd255;
            lower_reg  <= 8'd0;
            margin_reg <= 15'd256;
            tick_reg   <= '0;
            taken_reg  <= '0;
            fsum_reg   <= '0;
            bsum_reg   <= '0;
            fheld_reg  <= '0;
            bheld_reg  <= '0;
            hit_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    dirc_pkg::CFG_RATE:   rate_reg   <= cfg_data[6:0];
                    dirc_pkg::CFG_COUNT:  spa_reg    <= cfg_data[3:0];
                    dirc_pkg::CFG_UPPER:  upper_reg  <= cfg_data[7:0];
                    dirc_pkg::CFG_LOWER:  lower_reg  <= cfg_data[7:0];
                    dirc_pkg::CFG_MARGIN: margin_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (in_fire)
            begin
                hit_reg <= (tick_inc == TW'(target));
                if (tick_inc == TW'(target) || tick_inc >= TW'(STORE_DEPTH))
                    tick_reg <= '0;
                else
                    tick_reg <= tick_inc;
            end
            if (cmd.accum)
            begin
                fsum_reg  <= fsum_reg + 12'(fs_reg);
                bsum_reg  <= bsum_reg + 12'(bs_reg);
                taken_reg <= taken_reg + 4'd1;
            end
            if (cmd.clear)
            begin
                fsum_reg  <= '0;
                bsum_reg  <= '0;
                taken_reg <= '0;
            end
            if (cmd.finish)
            begin
                fheld_reg <= fcm;
                bheld_reg <= bcm;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            fs_reg <= front_sample;
            bs_reg <= back_sample;
        end
        if (cmd.div_start)
        begin
            fq_reg <= fsum_reg + 12'(fs_reg);
            bq_reg <= bsum_reg + 12'(bs_reg);
            fr_reg <= '0;
            br_reg <= '0;
            dv_reg <= taken_reg + 4'd1;
        end
        if (cmd.div_step)
        begin
            {fr_reg, fq_reg} <= 16'(dstep(fq_reg, fr_reg, dv_reg) >> 1);
            {br_reg, bq_reg} <= 16'(dstep(bq_reg, br_reg, dv_reg) >> 1);
        end
        if (cmd.conv_load)
        begin
            fok_reg  <= fq_reg[7:0] <= upper_reg && fq_reg[7:0] >= lower_reg;
            bok_reg  <= bq_reg[7:0] <= upper_reg && bq_reg[7:0] >= lower_reg;
            fneg_reg <= fset[59];
            bneg_reg <= bset[59];
            // quotient fits 24 bits, so the top 8 numerator bits start as remainder
            frem_reg <= {20'd0, fset[58:51]};
            brem_reg <= {20'd0, bset[58:51]};
            fnum_reg <= fset[50:27];
            bnum_reg <= bset[50:27];
            fden_reg <= fset[26:0];
            bden_reg <= bset[26:0];
            fcq_reg  <= '0;
            bcq_reg  <= '0;
        end
        if (cmd.conv_step)
        begin
            fnum_reg <= {fnum_reg[22:0], 1'b0};
            bnum_reg <= {bnum_reg[22:0], 1'b0};
            if (!ftr[28])
            begin
                frem_reg <= ftr[27:0];
                fcq_reg  <= {fcq_reg[22:0], 1'b1};
            end
            else
            begin
                frem_reg <= {frem_reg[26:0], fnum_reg[23]};
                fcq_reg  <= {fcq_reg[22:0], 1'b0};
            end
            if (!btr[28])
            begin
                brem_reg <= btr[27:0];
                bcq_reg  <= {bcq_reg[22:0], 1'b1};
            end
            else
            begin
                brem_reg <= {brem_reg[26:0], bnum_reg[23]};
                bcq_reg  <= {bcq_reg[22:0], 1'b0};
            end
        end
        if (cmd.finish)
        begin
            side_state <= st;
            front_cm   <= fcm;
            back_cm    <= bcm;
            mean_cm    <= sum[16:1];
            front_ok   <= fok_reg;
            back_ok    <= bok_reg;
        end
    end
endmodule
`default_nettype wire

[design/dual_ir_range_classifier_unit.sv]
`default_nettype none
// Flow: a tick with no reading passes through the accumulate state and frees the input;
//   a tick that completes a reading raises out_valid after accumulate, 12 average-divider
//   steps, load, 24 conversion steps and finish.
// Input: a new item is taken only when the controller is idle; a reading holds the input
//   through the bit-serial dividers and while an earlier result waits for out_ready.
// Reset: rst_n asynchronous, clears counts, sums, held distances; config to defaults.
module dual_ir_range_classifier_unit #(
    parameter int STORE_DEPTH = 10
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_ready,
    input  wire  [7:0]        front_sample,
    input  wire  [7:0]        back_sample,
    output logic              out_valid,
    input  wire               out_ready,
    output logic [1:0]        side_state,
    output logic signed [15:0] front_cm,
    output logic signed [15:0] back_cm,
    output logic signed [15:0] mean_cm,
    output logic              front_ok,
    output logic              back_ok,
    input  wire               cfg_we,
    input  wire  [2:0]        cfg_idx,
    input  wire  [14:0]       cfg_data
);
    dirc_pkg::dirc_cmd_t    cmd;
    dirc_pkg::dirc_status_t status;
    logic idle, in_fire, ov_reg;

    // input taken only when controller idle; output register holds result
    assign in_ready  = idle;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (cmd.finish)
            ov_reg <= 1'b1;
        else if (out_ready)
            ov_reg <= 1'b0;
    end

    dirc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
        .out_busy(ov_reg && !out_ready), .status(status), .cmd(cmd), .idle(idle)
    );

    dirc_datapath #(.STORE_DEPTH(STORE_DEPTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
        .front_sample(front_sample), .back_sample(back_sample),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
        .cmd(cmd), .status(status),
        .side_state(side_state), .front_cm(front_cm), .back_cm(back_cm),
        .mean_cm(mean_cm), .front_ok(front_ok), .back_ok(back_ok)
    );
endmodule
`default_nettype wire

[verif/dual_ir_range_classifier_unit_tb.sv]
`default_nettype none
module dual_ir_range_classifier_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 10;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [7:0] front;
        logic [7:0] back;
    } tick_t;

    typedef struct packed {
        dirc_pkg::side_t   side;
        logic signed [15:0] fcm;
        logic signed [15:0] bcm;
        logic signed [15:0] mcm;
        logic              fok;
        logic              bok;
    } reading_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [7:0] front_sample;
    logic [7:0] back_sample;
    logic out_valid;
    logic out_ready;
    logic [1:0] side_state;
    logic signed [15:0] front_cm;
    logic signed [15:0] back_cm;
    logic signed [15:0] mean_cm;
    logic front_ok;
    logic back_ok;
    logic cfg_we;
    logic [2:0] cfg_idx;
    logic [14:0] cfg_data;

    dual_ir_range_classifier_unit #(.STORE_DEPTH(DEPTH)) u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .front_sample(front_sample), .back_sample(back_sample),
        .out_valid(out_valid), .out_ready(out_ready),
        .side_state(side_state), .front_cm(front_cm), .back_cm(back_cm),
        .mean_cm(mean_cm), .front_ok(front_ok), .back_ok(back_ok),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
    );

    // Clock: 10 ns period
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Predictor copy of the registers and state
    int unsigned rate_pct, spa, up_lim, lo_lim, margin_q;
    int unsigned tick_cnt, taken_cnt, fsum, bsum;
    int          fheld, bheld;

    tick_t    tick_q[$];       // items waiting for the driver
    reading_t reading_q[$];    // predicted readings not yet seen
    int       mismatches;
    int       cycles;
    bit       quiet;           // no idling on either side
    int       rx_hold;         // cycles left in a long receiver hold-off
    bit       in_taken;        // input item accepted at the last rising edge
    int       tx_gap, rx_gap;
    int       tick_sent;

    function automatic int cm_of(int unsigned x);
        longint d, num, den, r, q;
        d = 95 * longint'(x) - 1071;
        num = 64'sd1305600000 - 10752 * d;
        den = 100 * d;
        if (den < 0)
        begin
            den = -den;
            num = -num;
        end
        // floor((2num+den)/(2den))
        q = (2 * num + den) / (2 * den);
        if (((2 * num + den) % (2 * den)) != 0 && (2 * num + den) < 0)
            q = q - 1;
        r = q;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return int'(r);
    endfunction

    task automatic predict_tick(input tick_t t);
        int unsigned rate, target, favg, bavg;
        bit fk, bk;
        int diff, sum, mean;
        reading_t rd;
        rate = (rate_pct > 100) ? 100 : rate_pct;
        target = 1 + (100 - rate) / 10;
        tick_cnt++;
        if (tick_cnt == target)
            tick_cnt = 0;
        else
        begin
            if (tick_cnt >= DEPTH)
                tick_cnt = 0;
            return;
        end
        if (spa == 0)
        begin
            taken_cnt = 0;
            fsum = 0;
            bsum = 0;
            return;
        end
        fsum += t.front;
        bsum += t.back;
        taken_cnt++;
        if (taken_cnt < spa)
            return;
        favg = fsum / taken_cnt;
        bavg = bsum / taken_cnt;
        taken_cnt = 0;
        fsum = 0;
        bsum = 0;
        fk = favg <= up_lim && favg >= lo_lim;
        bk = bavg <= up_lim && bavg >= lo_lim;
        if (fk)
            fheld = cm_of(favg);
        if (bk)
            bheld = cm_of(bavg);
        diff = fheld - bheld;
        if (fk && (!bk || diff > int'(margin_q)))
            rd.side = dirc_pkg::SIDE_FRONT;
        else if (bk && (!fk || -diff > int'(margin_q)))
            rd.side = dirc_pkg::SIDE_BACK;
        else if (!fk && !bk)
            rd.side = dirc_pkg::SIDE_ERROR;
        else
            rd.side = dirc_pkg::SIDE_PARALLEL;
        sum = fheld + bheld;
        mean = (sum >= 0) ? sum / 2 : -((-sum + 1) / 2);
        rd.fcm = fheld[15:0];
        rd.bcm = bheld[15:0];
        rd.mcm = mean[15:0];
        rd.fok = fk;
        rd.bok = bk;
        reading_q.push_back(rd);
    endtask

    // Driver: presents queued items; a new one only once the last was accepted
    always @(negedge clk)
    begin
        bit slot_free;
        if (rst_n)
        begin
            slot_free = !in_valid || in_taken;
            in_taken = 1'b0;
            if (slot_free)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    in_valid <= 1'b0;
                end
                else if (tick_q.size() > 0)
                begin
                    if (!quiet && $urandom_range(0, 7) == 0)
                    begin
                        tx_gap = $urandom_range(1, 12);
                        in_valid <= 1'b0;
                    end
                    else
                    begin
                        in_valid <= 1'b1;
                        front_sample <= tick_q[0].front;
                        back_sample <= tick_q[0].back;
                        void'(tick_q.pop_front());
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Prediction at acceptance edge
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            predict_tick({front_sample, back_sample});
            tick_sent++;
            in_taken = 1'b1;
        end
    end

    // Receiver ready with random stalls and a long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rx_hold > 0)
            begin
                rx_hold--;
                out_ready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                out_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                rx_gap = $urandom_range(1, 12);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Monitor: compare each reading with the oldest prediction
    always @(posedge clk)
    begin
        reading_t ex;
        if (rst_n && out_valid && out_ready)
        begin
            if (reading_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected reading side=%0d f=%0d b=%0d", side_state,
                             front_cm, back_cm);
            end
            else
            begin
                ex = reading_q.pop_front();
                if (side_state !== ex.side || front_cm !== ex.fcm || back_cm !== ex.bcm
                    || mean_cm !== ex.mcm || front_ok !== ex.fok || back_ok !== ex.bok)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %0d %0d %0d %0d %b%b got %0d %0d %0d %0d %b%b",
                                 ex.side, ex.fcm, ex.bcm, ex.mcm, ex.fok, ex.bok,
                                 side_state, front_cm, back_cm, mean_cm, front_ok, back_ok);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("dual_ir_range_classifier_unit_tb NOT OK");
            $finish;
        end
    end

    task automatic idle_wait();
        while (tick_q.size() > 0 || in_valid)
            @(posedge clk);
        while (reading_q.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int unsigned val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val[14:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            dirc_pkg::CFG_RATE:   rate_pct = val & 32'h7F;
            dirc_pkg::CFG_COUNT:  spa = val & 32'hF;
            dirc_pkg::CFG_UPPER:  up_lim = val & 32'hFF;
            dirc_pkg::CFG_LOWER:  lo_lim = val & 32'hFF;
            dirc_pkg::CFG_MARGIN: margin_q = val & 32'h7FFF;
            default: ;
        endcase
    endtask

    task automatic push_tick(input int unsigned f, input int unsigned b);
        tick_t t;
        t.front = f[7:0];
        t.back = b[7:0];
        tick_q.push_back(t);
    endtask

    // Well-formed reading: a set of samples near one level, plus noise
    task automatic push_burst(input int n);
        int unsigned fl, bl;
        fl = $urandom_range(0, 255);
        bl = $urandom_range(0, 255);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 5) == 0)
                push_tick($urandom, $urandom);
            else
                push_tick((fl + $urandom_range(0, 6)) & 255, (bl + $urandom_range(0, 6)) & 255);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        front_sample = '0;
        back_sample = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = dirc_pkg::CFG_RATE;
        cfg_data = '0;
        mismatches = 0;
        cycles = 0;
        quiet = 1'b0;
        rx_hold = 0;
        in_taken = 1'b0;
        tx_gap = 0;
        rx_gap = 0;
        tick_sent = 0;
        rate_pct = 100;
        spa = 10;
        up_lim = 255;
        lo_lim = 0;
        margin_q = 256;
        tick_cnt = 0;
        taken_cnt = 0;
        fsum = 0;
        bsum = 0;
        fheld = 0;
        bheld = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: one sample per reading, rate 100, field extremes
        write_reg(dirc_pkg::CFG_COUNT, 1);
        push_tick(0, 255);
        push_tick(255, 0);
        push_tick(11, 12);   // near the pole of the conversion
        push_tick(12, 11);
        push_tick(128, 128);
        push_tick(85, 170);
        idle_wait();
        // lower above upper: nothing in range, held distances kept
        write_reg(dirc_pkg::CFG_UPPER, 10);
        write_reg(dirc_pkg::CFG_LOWER, 200);
        push_tick(100, 100);
        push_tick(5, 250);
        idle_wait();
        // one side in range, then both at the limits
        write_reg(dirc_pkg::CFG_UPPER, 150);
        write_reg(dirc_pkg::CFG_LOWER, 50);
        push_tick(100, 10);
        push_tick(10, 100);
        push_tick(50, 150);
        idle_wait();
        // margin extremes
        write_reg(dirc_pkg::CFG_UPPER, 255);
        write_reg(dirc_pkg::CFG_LOWER, 0);
        write_reg(dirc_pkg::CFG_MARGIN, 0);
        push_tick(60, 61);
        push_tick(61, 60);
        idle_wait();
        write_reg(dirc_pkg::CFG_MARGIN, 32767);
        push_tick(30, 200);
        idle_wait();
        // zero samples per average: output disabled
        write_reg(dirc_pkg::CFG_COUNT, 0);
        push_tick(1, 2);
        push_tick(3, 4);
        idle_wait();
        // rate zero: target beyond the store depth, no sample taken; rate above 100
        write_reg(dirc_pkg::CFG_COUNT, 2);
        write_reg(dirc_pkg::CFG_RATE, 0);
        push_tick(7, 7);
        push_tick(9, 9);
        idle_wait();
        write_reg(dirc_pkg::CFG_RATE, 127);
        push_tick(40, 90);
        push_tick(44, 94);
        idle_wait();
        // lower samples per average mid-run
        write_reg(dirc_pkg::CFG_COUNT, 5);
        push_tick(20, 220);
        push_tick(22, 222);
        push_tick(24, 224);
        idle_wait();
        write_reg(dirc_pkg::CFG_COUNT, 2);
        push_tick(26, 226);
        idle_wait();

        // Random phases
        for (int ph = 0; ph < 12; ph++)
        begin
            write_reg(dirc_pkg::CFG_RATE, (ph % 3 == 0) ? 100 : $urandom_range(0, 11) * 10 +
                      $urandom_range(0, 1) * $urandom_range(0, 9));
            write_reg(dirc_pkg::CFG_COUNT, (ph == 5) ? 10 : $urandom_range(1, 4));
            write_reg(dirc_pkg::CFG_UPPER, (ph % 4 == 0) ? 255 : $urandom_range(100, 255));
            write_reg(dirc_pkg::CFG_LOWER, (ph % 4 == 0) ? 0 : $urandom_range(0, 120));
            write_reg(dirc_pkg::CFG_MARGIN, (ph % 5 == 1) ? 32767 : $urandom_range(0, 2000));
            if (ph == 10)
                quiet = 1'b1;
            if (ph == 3)
            begin
                // long receiver hold-off while items keep coming
                rx_hold = 400;
                for (int i = 0; i < 10; i++)
                    push_burst(4);
            end
            else
            begin
                for (int i = 0; i < 10; i++)
                    push_burst(4);
            end
            idle_wait();
        end

        repeat (100) @(posedge clk);
        if (mismatches == 0 && reading_q.size() == 0)
            $display("dual_ir_range_classifier_unit_tb OK");
        else
            $display("dual_ir_range_classifier_unit_tb NOT OK");
        $finish;
    end
endmodule
`default_nettype wire

[dual_ir_range_classifier_unit.f]
design/dirc_pkg.sv
design/dirc_ctrl.sv
design/dirc_datapath.sv
design/dual_ir_range_classifier_unit.sv
verif/dual_ir_range_classifier_unit_tb.sv
